@@ src/ffba_pkg.sv @@
`timescale 1ns / 1ps

package ffba_pkg;

   // Operation codes carried in the request
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;

   // Status codes carried in the response
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_HEAP    = 2'd1;
   localparam logic [1:0] STS_TABLE   = 2'd2;
   localparam logic [1:0] STS_UNKNOWN = 2'd3;

   // Configuration register indexes
   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   // Search token walking down the cell chain, newest entry first
   typedef struct packed {
      logic        active;
      logic        fit_mode;  // 1: free block with size >= key, 0: start == key
      logic [32:0] key;
      logic        found;
      logic [31:0] start;
      logic [31:0] size;
   } token_type;

   // Write command broadcast to every cell
   typedef struct packed {
      logic        claim_fit;     // cell picked by the last fit search: free <= 0
      logic        release_find;  // cell picked by the last lookup: free <= 1
      logic        new_en;        // cell at index entry_count takes a new block
      logic [31:0] new_start;
      logic [31:0] new_size;
   } cmd_type;

endpackage

@@ src/ffba_cell.sv @@
`timescale 1ns / 1ps

// One block table entry. Passes the search token on to the next older entry.
module ffba_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   entry_count,
   input  ffba_pkg::cmd_type  cmd,
   input  ffba_pkg::token_type tok_i,
   output ffba_pkg::token_type tok_o
);

   logic [31:0] start_ff;
   logic [31:0] size_ff;
   logic        free_ff;
   logic        sel_fit_ff;
   logic        sel_find_ff;
   ffba_pkg::token_type tok_ff;
   ffba_pkg::token_type tok_in;

   logic in_use;
   logic is_new;
   logic hit;

   assign in_use = CNT_W'(INDEX) < entry_count;
   assign is_new = CNT_W'(INDEX) == entry_count;

   always_comb begin
      if (tok_i.fit_mode) begin
         hit = free_ff && ({1'b0, size_ff} >= tok_i.key);
      end else begin
         hit = start_ff == tok_i.key[31:0];
      end
      hit = hit && in_use && tok_i.active && !tok_i.found;
      tok_in = tok_i;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.start = start_ff;
         tok_in.size  = size_ff;
      end
   end

   // entry payload, undefined until written
   always_ff @(posedge clock) begin
      if (cmd.new_en && is_new) begin
         start_ff <= cmd.new_start;
         size_ff  <= cmd.new_size;
         free_ff  <= 1'b0;
      end else if (cmd.claim_fit && sel_fit_ff) begin
         free_ff <= 1'b0;
      end else if (cmd.release_find && sel_find_ff) begin
         free_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_fit_ff    <= 1'b0;
         sel_find_ff   <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         if (tok_i.active) begin
            if (tok_i.fit_mode) begin
               sel_fit_ff <= hit;
            end else begin
               sel_find_ff <= hit;
            end
         end
         tok_ff.active <= tok_in.active;
      end
      tok_ff.fit_mode <= tok_in.fit_mode;
      tok_ff.key      <= tok_in.key;
      tok_ff.found    <= tok_in.found;
      tok_ff.start    <= tok_in.start;
      tok_ff.size     <= tok_in.size;
   end

   assign tok_o = tok_ff;

endmodule

@@ src/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// req_     in   72     tdata: op[1:0], request_bytes[33:2], block_address[65:34]
// rsp_     out  72     tdata: result_address[31:0], status[33:32], reused[34],
//                      copy_bytes[66:35]
// csr_     in   32     wr_en, index (0 heap_base, 1 heap_limit_bytes), wdata
//
// One transaction at a time. A table search walks a token through the chain
// of MAX_BLOCKS cells, one cell per cycle, so allocate, free and a resize that
// keeps its block take one pass; a resize that moves its block needs two
// passes. Null frees, zero-size allocations and unused-op requests skip the
// search. Reset (synchronous, high) empties the table and restores the
// registers; entry contents need no clearing. A new request transaction is
// taken while the previous response still waits; a stalled response holds
// the next result back until rsp_tready.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // op, request_bytes, block_address
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // result_address, status, reused, copy_bytes
   // configuration writes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_FIT,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [31:0]      heap_base_ff;
   logic [31:0]      heap_limit_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      heap_used_ff;

   // current transaction
   logic [1:0]  op_ff;
   logic [31:0] req_bytes_ff;
   logic [32:0] rnd_ff;
   logic [31:0] ptr_ff;
   logic        is_move_ff;
   logic [31:0] old_size_ff;

   // result waiting for the output register
   logic [31:0] res_addr_ff;
   logic [1:0]  res_status_ff;
   logic        res_reused_ff;
   logic [31:0] res_copy_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_reused_ff;
   logic [31:0] rsp_copy_ff;

   ffba_pkg::token_type tok_inj_ff;
   ffba_pkg::cmd_type   cmd_ff;
   ffba_pkg::token_type chain [MAX_BLOCKS+1];

   // request fields
   logic [1:0]  in_op;
   logic [31:0] in_req;
   logic [31:0] in_ptr;
   logic [32:0] in_rnd;

   assign in_op  = req_tdata[1:0];
   assign in_req = req_tdata[33:2];
   assign in_ptr = req_tdata[65:34];
   assign in_rnd = ({1'b0, in_req} + 33'd7) & ~33'd7;

   // carve path arithmetic
   logic [33:0] total;
   logic [31:0] new_start;
   logic        table_full;

   assign total      = {2'b00, heap_used_ff} + 34'(HEADER_BYTES) + {1'b0, rnd_ff};
   assign new_start  = heap_base_ff + heap_used_ff + 32'(HEADER_BYTES);
   assign table_full = count_ff == CNT_W'(MAX_BLOCKS);

   logic accept;
   logic tok_done;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign tok_done   = chain[0].active;

   // cell chain: newest entry at the top, token moves toward index 0
   assign chain[MAX_BLOCKS] = tok_inj_ff;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
         ffba_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .entry_count (count_ff),
            .cmd         (cmd_ff),
            .tok_i       (chain[gi+1]),
            .tok_o       (chain[gi])
         );
      end
   endgenerate

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= 32'd0;
         heap_limit_ff <= 32'd1048576;
      end else if (csr_wr_en) begin
         case (csr_index)
            ffba_pkg::REG_HEAP_BASE:  heap_base_ff  <= csr_wdata;
            ffba_pkg::REG_HEAP_LIMIT: heap_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         count_ff          <= '0;
         heap_used_ff      <= 32'd0;
         rsp_valid_ff      <= 1'b0;
         tok_inj_ff.active <= 1'b0;
         cmd_ff.claim_fit    <= 1'b0;
         cmd_ff.release_find <= 1'b0;
         cmd_ff.new_en       <= 1'b0;
      end else begin
         // one-cycle pulses by default
         tok_inj_ff.active   <= 1'b0;
         cmd_ff.claim_fit    <= 1'b0;
         cmd_ff.release_find <= 1'b0;
         cmd_ff.new_en       <= 1'b0;

         if (cmd_ff.new_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff        <= in_op;
                  req_bytes_ff <= in_req;
                  rnd_ff       <= in_rnd;
                  ptr_ff       <= in_ptr;
                  is_move_ff   <= in_op == ffba_pkg::OP_RESIZE && in_ptr != 32'd0;
                  old_size_ff  <= 32'd0;
                  res_addr_ff   <= 32'd0;
                  res_status_ff <= ffba_pkg::STS_OK;
                  res_reused_ff <= 1'b0;
                  res_copy_ff   <= 32'd0;
                  tok_inj_ff.found <= 1'b0;
                  tok_inj_ff.start <= 32'd0;
                  tok_inj_ff.size  <= 32'd0;
                  if (in_op == ffba_pkg::OP_ALLOC ||
                      (in_op == ffba_pkg::OP_RESIZE && in_ptr == 32'd0)) begin
                     if (in_req == 32'd0) begin
                        state_ff <= ST_OUT;
                     end else begin
                        tok_inj_ff.active   <= 1'b1;
                        tok_inj_ff.fit_mode <= 1'b1;
                        tok_inj_ff.key      <= in_rnd;
                        state_ff            <= ST_FIT;
                     end
                  end else if (in_op == ffba_pkg::OP_FREE || in_op == ffba_pkg::OP_RESIZE) begin
                     if (in_ptr == 32'd0) begin
                        state_ff <= ST_OUT;
                     end else begin
                        tok_inj_ff.active   <= 1'b1;
                        tok_inj_ff.fit_mode <= 1'b0;
                        tok_inj_ff.key      <= {1'b0, in_ptr};
                        state_ff            <= ST_FIND;
                     end
                  end else begin
                     // unused opcode: all-zero response
                     state_ff <= ST_OUT;
                  end
               end
            end

            ST_FIND: begin
               if (tok_done) begin
                  if (!chain[0].found) begin
                     res_status_ff <= ffba_pkg::STS_UNKNOWN;
                     state_ff      <= ST_OUT;
                  end else if (op_ff == ffba_pkg::OP_FREE || req_bytes_ff == 32'd0) begin
                     cmd_ff.release_find <= 1'b1;
                     state_ff            <= ST_OUT;
                  end else if (chain[0].size >= req_bytes_ff) begin
                     // block already large enough, keep it
                     res_addr_ff <= ptr_ff;
                     state_ff    <= ST_OUT;
                  end else begin
                     old_size_ff         <= chain[0].size;
                     tok_inj_ff.active   <= 1'b1;
                     tok_inj_ff.fit_mode <= 1'b1;
                     tok_inj_ff.key      <= rnd_ff;
                     tok_inj_ff.found    <= 1'b0;
                     state_ff            <= ST_FIT;
                  end
               end
            end

            ST_FIT: begin
               if (tok_done) begin
                  state_ff <= ST_OUT;
                  if (chain[0].found) begin
                     // reuse the newest free block that fits
                     cmd_ff.claim_fit <= 1'b1;
                     if (!is_move_ff) begin
                        res_addr_ff   <= chain[0].start;
                        res_reused_ff <= 1'b1;
                     end else if (chain[0].start != 32'd0) begin
                        cmd_ff.release_find <= 1'b1;
                        res_addr_ff   <= chain[0].start;
                        res_reused_ff <= 1'b1;
                        res_copy_ff   <= old_size_ff;
                     end
                  end else if (total > {2'b00, heap_limit_ff}) begin
                     res_status_ff <= ffba_pkg::STS_HEAP;
                  end else if (table_full) begin
                     res_status_ff <= ffba_pkg::STS_TABLE;
                  end else begin
                     // carve a new block from the top of the heap
                     cmd_ff.new_en    <= 1'b1;
                     cmd_ff.new_start <= new_start;
                     cmd_ff.new_size  <= rnd_ff[31:0];
                     heap_used_ff     <= total[31:0];
                     if (!is_move_ff) begin
                        res_addr_ff <= new_start;
                     end else if (new_start != 32'd0) begin
                        cmd_ff.release_find <= 1'b1;
                        res_addr_ff <= new_start;
                        res_copy_ff <= old_size_ff;
                     end
                  end
               end
            end

            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_reused_ff <= res_reused_ff;
                  rsp_copy_ff   <= res_copy_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_copy_ff, rsp_reused_ff, rsp_status_ff, rsp_addr_ff};

endmodule
